// ----- design/gmb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmb_pkg: shared constants and types for the Golomb encoder
// Field widths, register indexes, the control state type and a small
// priority encoder for the divisor.
// ----------------------------------------------------------------------------
package gmb_pkg;

   localparam int VALUE_BITS = 10;
   localparam int CHUNK_BITS = 64;
   localparam int DIV_BITS   = 11;
   localparam int N_BITS     = VALUE_BITS + 1;
   localparam int CNT_BITS   = $clog2(CHUNK_BITS + 1);
   localparam int RB_BITS    = $clog2(DIV_BITS + 1);
   localparam int STEP_BITS  = $clog2(N_BITS);
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [DIV_BITS-1:0] DIVISOR_RESET = DIV_BITS'(4);

   // register indexes
   localparam logic REG_DIVISOR     = 1'b0;
   localparam logic REG_SIGNED_MODE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_REMAP,
      S_UNARY,
      S_REMAINDER
   } state_type;

   // position of the highest set bit, zero for zero
   function automatic logic [RB_BITS-1:0] floor_log2(input logic [DIV_BITS-1:0] x);
      logic [RB_BITS-1:0] b;
      b = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         if (x[i]) begin
            b = RB_BITS'(i);
         end
      end
      return b;
   endfunction

endpackage

// ----- design/golomb_encoder.sv -----
`timescale 1ns / 1ps
// An accepted item runs through S_DIVIDE, where the bit-serial restoring
//   divider takes one quotient bit per cycle, then S_REMAP and S_UNARY.
// An item gives 1 to 16 chunks; they leave one per cycle unless stalled.
// A new item is taken while the last chunk waits.
// Reset (synchronous, active high) clears control state, divisor to 4 and
//   signed_mode to 0.
// ----------------------------------------------------------------------------
// golomb_encoder: Golomb coder with truncated-binary remainder
// Zigzag-maps signed values if enabled, divides bit-serially by the divisor
// and emits the unary part and the remainder as right-aligned chunks.
// ----------------------------------------------------------------------------
module golomb_encoder (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gmb_pkg::VALUE_BITS-1:0] req_value,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gmb_pkg::CHUNK_BITS-1:0] rsp_code_bits,
   output logic [gmb_pkg::CNT_BITS-1:0]   rsp_bit_count,
   output logic                           rsp_last,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gmb_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [gmb_pkg::DATA_BITS-1:0]  pwdata,
   output logic [gmb_pkg::DATA_BITS-1:0]  prdata,
   output logic                           pready
);
   import gmb_pkg::*;

   state_type             state_ff, state_in;
   logic [DIV_BITS-1:0]   divisor_ff, divisor_in;
   logic                  signed_ff, signed_in;
   logic [N_BITS-1:0]     n_ff, n_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [RB_BITS-1:0]    b_ff, b_in;
   logic [DIV_BITS-1:0]   rcode_ff, rcode_in;
   logic [RB_BITS-1:0]    rbits_ff, rbits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHUNK_BITS-1:0] code_ff, code_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  last_ff, last_in;

   logic                  wr_en;
   logic [DIV_BITS-1:0]   m_eff;
   logic [DIV_BITS:0]     trial;
   logic                  trial_ge;
   logic [DIV_BITS:0]     pow2;
   logic [DIV_BITS-1:0]   u_val;
   logic [N_BITS-1:0]     n_load;
   logic                  out_free;
   logic [CNT_BITS-1:0]   ubits;

   // configuration port
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      divisor_in = divisor_ff;
      signed_in  = signed_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_DIVISOR:     divisor_in = pwdata[DIV_BITS-1:0];
            REG_SIGNED_MODE: signed_in  = pwdata[0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DIVISOR:     prdata = DATA_BITS'(divisor_ff);
         REG_SIGNED_MODE: prdata = DATA_BITS'(signed_ff);
         default:         prdata = '0;
      endcase
   end

   // divisor zero codes as one
   assign m_eff = (divisor_ff == '0) ? DIV_BITS'(1) : divisor_ff;

   // zigzag map of the incoming value
   always_comb begin
      if (signed_ff && req_value[VALUE_BITS-1]) begin
         n_load = {~req_value, 1'b1};
      end else if (signed_ff) begin
         n_load = {req_value, 1'b0};
      end else begin
         n_load = {1'b0, req_value};
      end
   end

   // one restoring division step
   assign trial    = {rem_ff, n_ff[N_BITS-1]};
   assign trial_ge = trial >= {1'b0, m_eff};

   // truncated-binary threshold u = 2^(b+1) - m
   assign pow2  = (DIV_BITS + 1)'(1) << (b_ff + RB_BITS'(1));
   assign u_val = DIV_BITS'(pow2 - {1'b0, m_eff});

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ubits    = CNT_BITS'(n_ff) + CNT_BITS'(1);
   assign req_stall = (state_ff != S_IDLE);

   // control and datapath next state
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      b_in         = b_ff;
      rcode_in     = rcode_ff;
      rbits_in     = rbits_ff;
      code_in      = code_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in     = n_load;
               rem_in   = '0;
               step_in  = STEP_BITS'(N_BITS - 1);
               b_in     = floor_log2(m_eff);
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            rem_in  = trial_ge ? DIV_BITS'(trial - {1'b0, m_eff}) : DIV_BITS'(trial);
            n_in    = {n_ff[N_BITS-2:0], trial_ge};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = S_REMAP;
            end
         end
         S_REMAP: begin
            if (rem_ff < u_val) begin
               rcode_in = rem_ff;
               rbits_in = b_ff;
            end else begin
               rcode_in = rem_ff + u_val;
               rbits_in = b_ff + RB_BITS'(1);
            end
            state_in = S_UNARY;
         end
         S_UNARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (int'(n_ff) >= CHUNK_BITS) begin
                  // full chunk of ones
                  code_in  = '1;
                  count_in = CNT_BITS'(CHUNK_BITS);
                  last_in  = 1'b0;
                  n_in     = N_BITS'(int'(n_ff) - CHUNK_BITS);
               end else begin
                  // q mod chunk ones, then the stop zero
                  code_in  = ~({CHUNK_BITS{1'b1}} << ubits) & ~CHUNK_BITS'(1);
                  count_in = ubits;
                  last_in  = (rbits_ff == '0);
                  state_in = (rbits_ff == '0) ? S_IDLE : S_REMAINDER;
               end
            end
         end
         S_REMAINDER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               code_in      = CHUNK_BITS'(rcode_ff);
               count_in     = CNT_BITS'(rbits_ff);
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         divisor_ff   <= DIVISOR_RESET;
         signed_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         divisor_ff   <= divisor_in;
         signed_ff    <= signed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      b_ff     <= b_in;
      rcode_ff <= rcode_in;
      rbits_ff <= rbits_in;
      code_ff  <= code_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_bits = code_ff;
   assign rsp_bit_count = count_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   // an accepted item always starts the divider
   a_accept_divide: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DIVIDE)
      else $error("item accepted without starting division");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVIDE || state_ff == S_REMAP |-> rem_ff < m_eff)
      else $error("partial remainder not below divisor");

   // a chunk carries between one and a full chunk of bits
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_count != '0 && int'(rsp_bit_count) <= CHUNK_BITS)
      else $error("chunk bit count out of range");

   // no bits above the valid count
   a_code_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_bits >> rsp_bit_count) == '0)
      else $error("chunk has bits above its count");

   // a short chunk that is not last must be the unary chunk ending in zero
   a_unary_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && int'(rsp_bit_count) != CHUNK_BITS |-> !rsp_code_bits[0])
      else $error("non-final short chunk lacks unary stop bit");
`endif

endmodule

// ----- sim/golomb_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golomb_encoder_tb: self-checking bench for the Golomb chunk encoder
// Drives values under a series of divisor and signed-mode settings, predicts
// every output chunk in a scoreboard and compares each accepted chunk field
// by field. Both channels idle and stall at random; one phase holds the
// result side off long enough to back the block up.
// ----------------------------------------------------------------------------
module golomb_encoder_tb;
   import gmb_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 20;
   localparam int RANDOM_PHASES    = 16;
   localparam int PHASE_ITEMS      = 27;

   localparam logic [CHUNK_BITS-1:0] ALL_ONES       = {CHUNK_BITS{1'b1}};
   localparam logic [CHUNK_BITS-1:0] ONES_THEN_ZERO = {{(CHUNK_BITS-1){1'b1}}, 1'b0};

   typedef struct packed {
      logic [CHUNK_BITS-1:0] code_bits;
      logic [CNT_BITS-1:0]   bit_count;
      logic                  last;
   } chunk_type;

   // predicts the chunk stream and checks it in order
   class chunk_scoreboard_type;
      logic [DIV_BITS-1:0] divisor     = DIVISOR_RESET;
      logic                signed_mode = 1'b0;
      chunk_type           pending_chunks[$];
      int                  mismatches  = 0;

      function void set_reg(logic idx, logic [DATA_BITS-1:0] data);
         if (idx == REG_DIVISOR) begin
            divisor = data[DIV_BITS-1:0];
         end else begin
            signed_mode = data[0];
         end
      endfunction

      function int pending();
         return pending_chunks.size();
      endfunction

      function void queue_chunk(logic [CHUNK_BITS-1:0] bits, int count, logic last);
         chunk_type c;
         c.code_bits = bits & ((count >= CHUNK_BITS) ? ALL_ONES
                                                     : ((64'd1 << count) - 64'd1));
         c.bit_count = CNT_BITS'(count);
         c.last      = last;
         pending_chunks = {pending_chunks, c};
      endfunction

      // code one accepted value into its chunks
      function void note_value(logic [VALUE_BITS-1:0] v);
         logic [VALUE_BITS-1:0] flipped;
         int n, m, q, r, b, u, rbits;
         flipped = ~v;
         m = (divisor == '0) ? 1 : int'(divisor);
         // zigzag map in signed mode
         if (!signed_mode) begin
            n = int'(v);
         end else if (v[VALUE_BITS-1]) begin
            n = 2 * int'(flipped) + 1;
         end else begin
            n = 2 * int'(v);
         end
         q = n / m;
         r = n % m;
         b = 0;
         while ((m >> (b + 1)) != 0) begin
            b++;
         end
         u = (1 << (b + 1)) - m;
         rbits = (r < u) ? b : b + 1;
         // unary part: full chunks of ones, then ones and a closing zero
         while (q >= CHUNK_BITS) begin
            queue_chunk(ALL_ONES, CHUNK_BITS, 1'b0);
            q -= CHUNK_BITS;
         end
         queue_chunk(ONES_THEN_ZERO, q + 1, rbits == 0);
         // truncated-binary remainder, skipped when it has no bits
         if (rbits != 0) begin
            queue_chunk((r < u) ? CHUNK_BITS'(r) : CHUNK_BITS'(r + u), rbits, 1'b1);
         end
      endfunction

      function void check_chunk(logic [CHUNK_BITS-1:0] bits, logic [CNT_BITS-1:0] count,
                                logic last);
         chunk_type got, want;
         got = {bits, count, last};
         if (pending_chunks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected chunk: bits=%h count=%0d last=%0b", bits, count, last);
            end
            return;
         end
         want = pending_chunks.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("chunk mismatch: expected bits=%h count=%0d last=%0b",
                        want.code_bits, want.bit_count, want.last);
               $display("                got      bits=%h count=%0d last=%0b",
                        bits, count, last);
            end
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [CHUNK_BITS-1:0] rsp_code_bits;
   logic [CNT_BITS-1:0]   rsp_bit_count;
   logic                  rsp_last;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [ADDR_BITS-1:0]  paddr     = '0;
   logic [DATA_BITS-1:0]  pwdata    = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   bit steady        = 1'b0;  // no idling on either side
   int hold_requests = 0;

   chunk_scoreboard_type results = new;

   golomb_encoder u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_bits (rsp_code_bits),
      .rsp_bit_count (rsp_bit_count),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // monitors and watchdog
   always @(posedge clock) begin
      int quiet_cycles;
      bit moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         results.note_value(req_value);
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results.check_chunk(rsp_code_bits, rsp_bit_count, rsp_last);
         moved = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
         moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("golomb_encoder verification failed");
         $finish;
      end
   end

   // result side: random stall before each chunk, long hold on request
   initial begin
      int wait_cycles;
      int holds_served;
      holds_served = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_requests > holds_served) begin
            holds_served++;
            wait_cycles = LONG_HOLD_CYCLES;
         end else if (steady) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 4);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_value(input logic [VALUE_BITS-1:0] v);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and let every predicted chunk come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (results.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      results.set_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are random; the block must ignore them
   task automatic set_mode(input logic [DIV_BITS-1:0] div, input logic sgn);
      logic [DATA_BITS-1:0] data;
      drain_results();
      data = $urandom();
      data[DIV_BITS-1:0] = div;
      write_reg(REG_DIVISOR, data);
      data = $urandom();
      data[0] = sgn;
      write_reg(REG_SIGNED_MODE, data);
   endtask

   function automatic logic [DIV_BITS-1:0] pick_divisor();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 6))
               0:       return DIV_BITS'(0);
               1:       return DIV_BITS'(1);
               2:       return DIV_BITS'(2);
               3:       return DIV_BITS'(1023);
               4:       return DIV_BITS'(1024);
               5:       return DIV_BITS'(1025);
               default: return DIV_BITS'(2047);
            endcase
         end
         1, 2:    return DIV_BITS'($urandom_range(1, 16));
         3:       return DIV_BITS'($urandom_range(17, 300));
         4:       return DIV_BITS'($urandom_range(1, 1024));
         default: return DIV_BITS'($urandom_range(1025, 2047));
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 4))
            0:       return VALUE_BITS'(0);
            1:       return VALUE_BITS'(1);
            2:       return VALUE_BITS'(511);
            3:       return VALUE_BITS'(512);
            default: return VALUE_BITS'(1023);
         endcase
      end
      return VALUE_BITS'($urandom_range(0, 1023));
   endfunction

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: divisor 4, unsigned
      send_value(10'd0);
      send_value(10'd1023);
      send_value(10'd3);
      send_value(10'd4);
      send_value(10'd7);
      // divisor one: no remainder chunk, unary chunk carries last
      set_mode(11'd1, 1'b0);
      send_value(10'd0);
      send_value(10'd63);
      send_value(10'd64);
      send_value(10'd1023);
      // divisor zero behaves as one
      set_mode(11'd0, 1'b0);
      send_value(10'd1);
      send_value(10'd128);
      // largest divisor, signed extremes
      set_mode(11'd2047, 1'b1);
      send_value(10'h200);
      send_value(10'h1FF);
      send_value(10'h3FF);
      send_value(10'h000);
      set_mode(11'd1024, 1'b1);
      send_value(10'h200);
      send_value(10'h001);
      // above-range divisor: remainder needs the long form
      set_mode(11'd1025, 1'b0);
      send_value(10'd1023);
      // divisor five hits both remainder lengths
      set_mode(11'd5, 1'b1);
      send_value(10'd0);
      send_value(10'd1);
      send_value(10'd2);
      send_value(10'd3);
      send_value(10'd4);
      send_value(10'h3FF);
      send_value(10'h3FE);

      // random phases; one of them backs the block up
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_mode(pick_divisor(), 1'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);
         if (p == 5) begin
            steady = 1'b0;
            hold_requests++;
         end
         repeat (PHASE_ITEMS) send_value(pick_value());
      end

      drain_results();
      if (results.mismatches == 0 && results.pending() == 0) begin
         $display("golomb_encoder verification clean");
      end else begin
         $display("golomb_encoder verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/gmb_pkg.sv
design/golomb_encoder.sv
sim/golomb_encoder_tb.sv
